[rtl/easing_curve_eval_assert.svh]
// ----------------------------------------------------------------------------
// Easing curve evaluator assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef EASING_CURVE_EVAL_ASSERT_SVH
`define EASING_CURVE_EVAL_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define ECE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("easing_curve_eval: check failed");

// Next-cycle implication, disabled while reset is low
`define ECE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("easing_curve_eval: check failed");

`endif

[rtl/ece_pkg.sv]
// ----------------------------------------------------------------------------
// Easing curve evaluator package
// Curve codes, pipeline control types, constants and the sine table builder.
// ----------------------------------------------------------------------------
package ece_pkg;

  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned SINE_DEPTH_DEF = 256;

  // pi/2 in Q.30
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // Taylor series divisors (2n)(2n+1), n = 1..12
  localparam longint unsigned SERIES_DIV [12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  // Overshoot curves: 2a in hundredths and the denominator 100 - 2a
  localparam int unsigned OVER_TWO_A [5] = '{50, 60, 70, 76, 80};
  localparam int unsigned OVER_DEN   [5] = '{50, 40, 30, 24, 20};

  typedef enum logic [4:0] {
    CRV_LINEAR      = 5'd0,
    CRV_IN2         = 5'd1,
    CRV_IN3         = 5'd2,
    CRV_IN4         = 5'd3,
    CRV_OUT2        = 5'd4,
    CRV_OUT3        = 5'd5,
    CRV_OUT4        = 5'd6,
    CRV_LINEAR_ALT  = 5'd7,
    CRV_SMOOTH      = 5'd8,
    CRV_INOUT2      = 5'd9,
    CRV_INOUT3      = 5'd10,
    CRV_INOUT4      = 5'd11,
    CRV_OUTIN2      = 5'd12,
    CRV_OUTIN3      = 5'd13,
    CRV_OUTIN4      = 5'd14,
    CRV_STEP_END    = 5'd15,
    CRV_STEP_START  = 5'd16,
    CRV_IN2_ALT     = 5'd17,
    CRV_SINE_OUT    = 5'd18,
    CRV_SINE_IN     = 5'd19,
    CRV_SINE_INOUT  = 5'd20,
    CRV_SINE_OUTIN  = 5'd21,
    CRV_OVER0       = 5'd22,
    CRV_OVER1       = 5'd23,
    CRV_OVER2       = 5'd24,
    CRV_OVER3       = 5'd25,
    CRV_OVER4       = 5'd26,
    CRV_OVER_MIR0   = 5'd27,
    CRV_OVER_MIR1   = 5'd28,
    CRV_OVER_MIR2   = 5'd29,
    CRV_OVER_MIR3   = 5'd30,
    CRV_OVER_MIR4   = 5'd31
  } curve_e;

  typedef enum logic [2:0] {
    MODE_LIN,
    MODE_POW,
    MODE_SMOOTH,
    MODE_SINE,
    MODE_OVER
  } mode_e;

  typedef enum logic [1:0] {
    POW2,
    POW3,
    POW4
  } pow_e;

  // Control that travels down the pipeline with each beat
  typedef struct packed {
    mode_e      mode;
    pow_e       pow_sel;
    logic [2:0] over_sel;
    logic       inv;
    logic       blend;
    logic       hi;
  } ctrl_t;

  // Quarter-wave sine entry from x = angle in Q.30, scaled to frac bits
  function automatic longint unsigned sine_entry(longint unsigned x, int unsigned frac);
    longint unsigned x2;
    longint unsigned term;
    longint          s;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    for (int n = 0; n < 12; n++) begin
      term = ((term * x2) >> 30) / SERIES_DIV[n];
      if ((n % 2) == 0) begin
        s = s - longint'(term);
      end else begin
        s = s + longint'(term);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    if (s > (longint'(1) << 30)) begin
      s = longint'(1) << 30;
    end
    return ((longint'(s) * (longint'(1) << frac)) + (longint'(1) << 29)) >> 30;
  endfunction

endpackage

[rtl/ece_front.sv]
// ----------------------------------------------------------------------------
// Easing curve evaluator front stage
// Clamps the inputs, decodes the curve and forms the shaped argument x.
// ----------------------------------------------------------------------------
module ece_front #(
  parameter int unsigned FRAC_BITS = ece_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic [7:0]            command_i,
  input  logic [FRAC_BITS:0]    t_in_i,
  output logic                  valid_o,
  output logic [FRAC_BITS:0]    x_o,
  output ece_pkg::ctrl_t        ctrl_o
);

  localparam int unsigned F = FRAC_BITS;
  localparam logic [F:0] ONE  = {1'b1, {F{1'b0}}};
  localparam logic [F:0] HALF = {2'b01, {(F-1){1'b0}}};

  logic [F:0]       t_sat;
  logic             hi;
  logic [F+1:0]     w2_wide;
  logic [F:0]       w;
  ece_pkg::curve_e  crv;
  ece_pkg::ctrl_t   ctrl_d;
  logic             inv_lo;
  logic             inv_hi;
  logic             step_end;
  logic             step_start;
  logic [F:0]       x_d;
  logic             valid_q;
  logic [F:0]       x_q;
  ece_pkg::ctrl_t   ctrl_q;

  // Clamp progress to one and unknown codes to linear
  assign t_sat = (t_in_i > ONE) ? ONE : t_in_i;
  assign crv   = (command_i > 8'd31) ? ece_pkg::CRV_LINEAR : ece_pkg::curve_e'(command_i[4:0]);
  assign hi    = (t_sat >= HALF);

  // Blend argument: 2t below the midpoint, 2t - 1 above it
  assign w2_wide = {t_sat, 1'b0} - (hi ? {1'b0, ONE} : '0);

  // Decode the curve into core mode and mirror flags
  always_comb begin
    ctrl_d          = '0;
    ctrl_d.mode     = ece_pkg::MODE_LIN;
    ctrl_d.pow_sel  = ece_pkg::POW2;
    ctrl_d.hi       = hi;
    inv_lo          = 1'b0;
    inv_hi          = 1'b0;
    step_end        = 1'b0;
    step_start      = 1'b0;
    case (crv)
      ece_pkg::CRV_IN2, ece_pkg::CRV_IN2_ALT: begin
        ctrl_d.mode = ece_pkg::MODE_POW;
      end
      ece_pkg::CRV_IN3: begin
        ctrl_d.mode = ece_pkg::MODE_POW; ctrl_d.pow_sel = ece_pkg::POW3;
      end
      ece_pkg::CRV_IN4: begin
        ctrl_d.mode = ece_pkg::MODE_POW; ctrl_d.pow_sel = ece_pkg::POW4;
      end
      ece_pkg::CRV_OUT2: begin
        ctrl_d.mode = ece_pkg::MODE_POW; inv_lo = 1'b1;
      end
      ece_pkg::CRV_OUT3: begin
        ctrl_d.mode = ece_pkg::MODE_POW; ctrl_d.pow_sel = ece_pkg::POW3; inv_lo = 1'b1;
      end
      ece_pkg::CRV_OUT4: begin
        ctrl_d.mode = ece_pkg::MODE_POW; ctrl_d.pow_sel = ece_pkg::POW4; inv_lo = 1'b1;
      end
      ece_pkg::CRV_SMOOTH: begin
        ctrl_d.mode = ece_pkg::MODE_SMOOTH;
      end
      ece_pkg::CRV_INOUT2: begin
        ctrl_d.mode = ece_pkg::MODE_POW; ctrl_d.blend = 1'b1; inv_hi = 1'b1;
      end
      ece_pkg::CRV_INOUT3: begin
        ctrl_d.mode = ece_pkg::MODE_POW; ctrl_d.pow_sel = ece_pkg::POW3;
        ctrl_d.blend = 1'b1; inv_hi = 1'b1;
      end
      ece_pkg::CRV_INOUT4: begin
        ctrl_d.mode = ece_pkg::MODE_POW; ctrl_d.pow_sel = ece_pkg::POW4;
        ctrl_d.blend = 1'b1; inv_hi = 1'b1;
      end
      ece_pkg::CRV_OUTIN2: begin
        ctrl_d.mode = ece_pkg::MODE_POW; ctrl_d.blend = 1'b1; inv_lo = 1'b1;
      end
      ece_pkg::CRV_OUTIN3: begin
        ctrl_d.mode = ece_pkg::MODE_POW; ctrl_d.pow_sel = ece_pkg::POW3;
        ctrl_d.blend = 1'b1; inv_lo = 1'b1;
      end
      ece_pkg::CRV_OUTIN4: begin
        ctrl_d.mode = ece_pkg::MODE_POW; ctrl_d.pow_sel = ece_pkg::POW4;
        ctrl_d.blend = 1'b1; inv_lo = 1'b1;
      end
      ece_pkg::CRV_STEP_END: begin
        step_end = 1'b1;
      end
      ece_pkg::CRV_STEP_START: begin
        step_start = 1'b1;
      end
      ece_pkg::CRV_SINE_OUT: begin
        ctrl_d.mode = ece_pkg::MODE_SINE;
      end
      ece_pkg::CRV_SINE_IN: begin
        ctrl_d.mode = ece_pkg::MODE_SINE; inv_lo = 1'b1;
      end
      ece_pkg::CRV_SINE_INOUT: begin
        ctrl_d.mode = ece_pkg::MODE_SINE; ctrl_d.blend = 1'b1; inv_lo = 1'b1;
      end
      ece_pkg::CRV_SINE_OUTIN: begin
        ctrl_d.mode = ece_pkg::MODE_SINE; ctrl_d.blend = 1'b1; inv_hi = 1'b1;
      end
      ece_pkg::CRV_OVER0, ece_pkg::CRV_OVER1, ece_pkg::CRV_OVER2,
      ece_pkg::CRV_OVER3, ece_pkg::CRV_OVER4: begin
        ctrl_d.mode     = ece_pkg::MODE_OVER;
        ctrl_d.over_sel = 3'(crv - ece_pkg::CRV_OVER0);
      end
      ece_pkg::CRV_OVER_MIR0, ece_pkg::CRV_OVER_MIR1, ece_pkg::CRV_OVER_MIR2,
      ece_pkg::CRV_OVER_MIR3, ece_pkg::CRV_OVER_MIR4: begin
        ctrl_d.mode     = ece_pkg::MODE_OVER;
        ctrl_d.over_sel = 3'(crv - ece_pkg::CRV_OVER_MIR0);
        inv_lo          = 1'b1;
      end
      default: begin
        ctrl_d.mode = ece_pkg::MODE_LIN;
      end
    endcase
    // Blends pick the mirror of the active half
    ctrl_d.inv = (ctrl_d.blend && hi) ? inv_hi : inv_lo;
  end

  // Shape the argument: blend rescale, then mirror, steps override
  always_comb begin
    w   = ctrl_d.blend ? w2_wide[F:0] : t_sat;
    x_d = ctrl_d.inv ? (ONE - w) : w;
    if (step_end) begin
      x_d = (t_sat == ONE) ? ONE : '0;
    end else if (step_start) begin
      x_d = (t_sat != '0) ? ONE : '0;
    end
  end

  // Hold the valid bit under reset, payload free-running
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    ctrl_q <= ctrl_d;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign ctrl_o  = ctrl_q;

endmodule

[rtl/ece_core.sv]
// ----------------------------------------------------------------------------
// Easing curve evaluator arithmetic core
// Three register stages for powers, sine table interpolation and overshoot divide.
// ----------------------------------------------------------------------------
module ece_core #(
  parameter int unsigned FRAC_BITS        = ece_pkg::FRAC_BITS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = ece_pkg::SINE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [FRAC_BITS:0]           x_i,
  input  ece_pkg::ctrl_t               ctrl_i,
  output logic                         valid_o,
  output logic signed [FRAC_BITS+3:0]  core_o,
  output ece_pkg::ctrl_t               ctrl_o
);

  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned DEPTH = SINE_TABLE_DEPTH;
  localparam int unsigned CW    = F + 4;
  localparam int unsigned IW    = $clog2(DEPTH + 1);
  localparam int unsigned K     = F + 7;
  localparam int unsigned NW    = 2 * F + 11;
  localparam int unsigned PW    = 2 * F + 10;
  localparam logic [F:0]       ONE     = {1'b1, {F{1'b0}}};
  localparam logic [2*F+1:0]   RND     = (2*F+2)'(1) << (F - 1);
  localparam logic signed [CW-1:0] ONE_S = {{(CW-F-1){1'b0}}, 1'b1, {F{1'b0}}};

  // Reciprocals of the overshoot denominators, scaled by 2^K
  localparam logic [F+2:0] RECIP [5] = '{
    (F+3)'((64'd1 << K) / ece_pkg::OVER_DEN[0]),
    (F+3)'((64'd1 << K) / ece_pkg::OVER_DEN[1]),
    (F+3)'((64'd1 << K) / ece_pkg::OVER_DEN[2]),
    (F+3)'((64'd1 << K) / ece_pkg::OVER_DEN[3]),
    (F+3)'((64'd1 << K) / ece_pkg::OVER_DEN[4])
  };

  // Quarter-wave sine table
  logic [F:0] sine_rom [DEPTH+1];

  for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
    localparam longint unsigned XK = (ece_pkg::PI_HALF_Q30 * k) / DEPTH;
    assign sine_rom[k] = (F+1)'(ece_pkg::sine_entry(XK, F));
  end

  // ---------------- stage A ----------------
  logic [2*F+1:0]        sq_a;
  logic [2*F+1:0]        sqr_a;
  logic [F+IW:0]         p_a;
  logic [F+8:0]          lin_u_a;
  logic signed [NW-1:0]  n_a;

  assign sq_a    = (2*F+2)'(x_i) * (2*F+2)'(x_i);
  assign sqr_a   = sq_a + RND;
  assign p_a     = (F+IW+1)'(x_i) * (F+IW+1)'(DEPTH);
  assign lin_u_a = (F+9)'(x_i) * (F+9)'(100)
                 - ((F+9)'(ece_pkg::OVER_TWO_A[ctrl_i.over_sel]) << F);
  assign n_a     = NW'($signed({1'b0, x_i}) * $signed(lin_u_a));

  logic                  valid_b_q;
  ece_pkg::ctrl_t        ctrl_b_q;
  logic [F:0]            x_b_q;
  logic [F:0]            r2_b_q;
  logic [IW-1:0]         idx_b_q;
  logic [F-1:0]          fr_b_q;
  logic signed [NW-1:0]  n_b_q;

  // ---------------- stage B ----------------
  logic [2*F+1:0]        cube_b;
  logic [2*F+1:0]        cuber_b;
  logic [IW-1:0]         idx_nx_b;
  logic [6:0]            den_b;
  logic signed [NW-1:0]  m_b;
  logic signed [F+10:0]  vs_b;
  logic [F+6:0]          v_b;
  logic [PW-1:0]         prod_b;

  assign cube_b   = (2*F+2)'(r2_b_q) * (2*F+2)'(x_b_q);
  assign cuber_b  = cube_b + RND;
  assign idx_nx_b = (idx_b_q == IW'(DEPTH)) ? idx_b_q : idx_b_q + 1'b1;
  assign den_b    = 7'(ece_pkg::OVER_DEN[ctrl_b_q.over_sel]);
  // Floor divide by 2^F first, offset positive, then reciprocal multiply
  assign m_b      = n_b_q + $signed(NW'(den_b) << (F - 1));
  assign vs_b     = $signed(m_b[NW-1:F]) + $signed((F+11)'(den_b) << F);
  assign v_b      = vs_b[F+6:0];
  assign prod_b   = PW'(v_b) * PW'(RECIP[ctrl_b_q.over_sel]);

  logic                  valid_c_q;
  ece_pkg::ctrl_t        ctrl_c_q;
  logic [F:0]            x_c_q;
  logic [F:0]            r2_c_q;
  logic [F:0]            r3_c_q;
  logic [F:0]            e0_c_q;
  logic [F:0]            e1_c_q;
  logic [F-1:0]          fr_c_q;
  logic [F+6:0]          v_c_q;
  logic [F+2:0]          qe_c_q;

  // ---------------- stage C ----------------
  logic [2*F+1:0]        quad_c;
  logic [2*F+1:0]        quadr_c;
  logic [F:0]            r4_c;
  logic [F:0]            delta_c;
  logic [2*F+1:0]        ip_c;
  logic [2*F+1:0]        ipr_c;
  logic [6:0]            den_c;
  logic [F+6:0]          rem_c;
  logic [F+2:0]          q_c;
  logic signed [CW-1:0]  smooth_c;
  logic signed [CW-1:0]  sine_c;
  logic signed [CW-1:0]  over_c;
  logic signed [CW-1:0]  core_d;

  assign quad_c   = (2*F+2)'(r3_c_q) * (2*F+2)'(x_c_q);
  assign quadr_c  = quad_c + RND;
  assign r4_c     = quadr_c[2*F:F];
  assign smooth_c = $signed(CW'(r2_c_q) * CW'(3)) - $signed(CW'(r3_c_q) << 1);
  assign delta_c  = e1_c_q - e0_c_q;
  assign ip_c     = (2*F+2)'(delta_c) * (2*F+2)'(fr_c_q);
  assign ipr_c    = ip_c + RND;
  assign sine_c   = $signed(CW'(e0_c_q) + CW'(ipr_c[2*F+1:F]));
  assign den_c    = 7'(ece_pkg::OVER_DEN[ctrl_c_q.over_sel]);
  // Reciprocal estimate is at most one short: one compare fixes it
  assign rem_c    = v_c_q - (F+7)'(qe_c_q) * (F+7)'(den_c);
  assign q_c      = (rem_c >= (F+7)'(den_c)) ? qe_c_q + 1'b1 : qe_c_q;
  assign over_c   = $signed(CW'(q_c)) - ONE_S;

  // Select the core result for this beat's curve family
  always_comb begin
    case (ctrl_c_q.mode)
      ece_pkg::MODE_POW: begin
        case (ctrl_c_q.pow_sel)
          ece_pkg::POW2: core_d = $signed(CW'(r2_c_q));
          ece_pkg::POW3: core_d = $signed(CW'(r3_c_q));
          ece_pkg::POW4: core_d = $signed(CW'(r4_c));
          default:       core_d = $signed(CW'(r2_c_q));
        endcase
      end
      ece_pkg::MODE_SMOOTH: core_d = smooth_c;
      ece_pkg::MODE_SINE:   core_d = sine_c;
      ece_pkg::MODE_OVER:   core_d = over_c;
      default:              core_d = $signed(CW'(x_c_q));
    endcase
  end

  logic                  valid_d_q;
  ece_pkg::ctrl_t        ctrl_d_q;
  logic signed [CW-1:0]  core_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
    end else begin
      valid_b_q <= valid_i;
      valid_c_q <= valid_b_q;
      valid_d_q <= valid_c_q;
    end
  end

  // Advance payload; table reads are registered here
  always_ff @(posedge clk_i) begin
    ctrl_b_q <= ctrl_i;
    x_b_q    <= x_i;
    r2_b_q   <= sqr_a[2*F:F];
    idx_b_q  <= p_a[F+IW-1:F];
    fr_b_q   <= p_a[F-1:0];
    n_b_q    <= n_a;

    ctrl_c_q <= ctrl_b_q;
    x_c_q    <= x_b_q;
    r2_c_q   <= r2_b_q;
    r3_c_q   <= cuber_b[2*F:F];
    e0_c_q   <= sine_rom[idx_b_q];
    e1_c_q   <= sine_rom[idx_nx_b];
    fr_c_q   <= fr_b_q;
    v_c_q    <= v_b;
    qe_c_q   <= prod_b[PW-1:K];

    ctrl_d_q <= ctrl_c_q;
    core_q   <= core_d;
  end

  assign valid_o = valid_d_q;
  assign core_o  = core_q;
  assign ctrl_o  = ctrl_d_q;

endmodule

[rtl/ece_back.sv]
// ----------------------------------------------------------------------------
// Easing curve evaluator back stage
// Undoes the mirror, folds blends into their half, saturates, registers out.
// ----------------------------------------------------------------------------
module ece_back #(
  parameter int unsigned FRAC_BITS = ece_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic signed [FRAC_BITS+3:0]  core_i,
  input  ece_pkg::ctrl_t               ctrl_i,
  output logic                         done_o,
  output logic signed [FRAC_BITS+1:0]  eased_value_o
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned CW = F + 4;
  localparam logic signed [CW-1:0] ONE_S  = {{(CW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [CW-1:0] HALF_S = ONE_S >>> 1;
  localparam logic signed [CW-1:0] OMAX   = {3'b000, {(F+1){1'b1}}};
  localparam logic signed [CW-1:0] OMIN   = {3'b111, {(F+1){1'b0}}};

  logic signed [CW-1:0] y;
  logic signed [CW-1:0] half_y;
  logic signed [CW-1:0] val;
  logic signed [CW-1:0] sat;
  logic                 done_q;
  logic signed [F+1:0]  value_q;

  // Mirror back, halve with round-half-up for blends, add the upper offset
  assign y      = ctrl_i.inv ? (ONE_S - core_i) : core_i;
  assign half_y = ((y + CW'(1)) >>> 1) + (ctrl_i.hi ? HALF_S : '0);
  assign val    = ctrl_i.blend ? half_y : y;
  assign sat    = (val > OMAX) ? OMAX : ((val < OMIN) ? OMIN : val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= sat[F+1:0];
  end

  assign done_o        = done_q;
  assign eased_value_o = value_q;

endmodule

[rtl/easing_curve_eval.sv]
// ----------------------------------------------------------------------------
// Easing curve evaluator
// Pipelined evaluator of 32 easing curves at a Q1.F progress value.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive command_i and t_in_i with start_i high; a beat is
//   taken on every rising edge where start_i is high and busy_o is low.
//   busy_o stays low, so one beat can enter every cycle.
//   Result channel: done_o pulses for one cycle with eased_value_o; the
//   receiver takes it on the edge that ends that cycle and cannot hold it.
//   A taken beat passes through five register stages in order: decode,
//   square/table address/overshoot numerator, cube/table read/reciprocal
//   multiply, fourth power/interpolate/divide correction, and
//   mirror/blend/saturate. Throughput is one beat per cycle, as the
//   pipeline never stalls.
//   Reset clears all valid bits; beats in flight are dropped and no result
//   appears until new beats are taken. Results leave in the order taken.
// ----------------------------------------------------------------------------
`include "easing_curve_eval_assert.svh"

module easing_curve_eval #(
  parameter int unsigned FRAC_BITS        = ece_pkg::FRAC_BITS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = ece_pkg::SINE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [7:0]                   command_i,
  input  logic [FRAC_BITS:0]           t_in_i,
  output logic                         done_o,
  output logic signed [FRAC_BITS+1:0]  eased_value_o
);

  localparam logic [FRAC_BITS:0] ONE_T = {1'b1, {FRAC_BITS{1'b0}}};

  logic                         take;
  logic                         front_valid;
  logic [FRAC_BITS:0]           front_x;
  ece_pkg::ctrl_t               front_ctrl;
  logic                         core_valid;
  logic signed [FRAC_BITS+3:0]  core_val;
  ece_pkg::ctrl_t               core_ctrl;

  // Always ready: the pipeline never stalls
  assign busy_o = 1'b0;
  assign take   = start_i && !busy_o;

  ece_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .command_i (command_i),
    .t_in_i    (t_in_i),
    .valid_o   (front_valid),
    .x_o       (front_x),
    .ctrl_o    (front_ctrl)
  );

  ece_core #(
    .FRAC_BITS        (FRAC_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .x_i     (front_x),
    .ctrl_i  (front_ctrl),
    .valid_o (core_valid),
    .core_o  (core_val),
    .ctrl_o  (core_ctrl)
  );

  ece_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (core_valid),
    .core_i        (core_val),
    .ctrl_i        (core_ctrl),
    .done_o        (done_o),
    .eased_value_o (eased_value_o)
  );

  // Every taken beat enters the pipe
  `ECE_ASSERT_NXT(a_front_fill, clk_i, rst_ni, take, front_valid)
  // A result only ever follows a taken beat
  `ECE_ASSERT_IMP(a_latency, clk_i, rst_ni, done_o, $past(take, 5))
  // Linear curve passes an in-range progress value straight through
  `ECE_ASSERT_IMP(a_linear, clk_i, rst_ni, done_o && $past(take && command_i == 8'(ece_pkg::CRV_LINEAR) && t_in_i <= ONE_T, 5), eased_value_o == $signed({1'b0, $past(t_in_i, 5)}))
  // End step only ever yields zero or one
  `ECE_ASSERT_IMP(a_step, clk_i, rst_ni, done_o && $past(take && command_i == 8'(ece_pkg::CRV_STEP_END), 5), eased_value_o == $signed({1'b0, ONE_T}) || eased_value_o == '0)

endmodule

[sim/easing_curve_checker.sv]
// ----------------------------------------------------------------------------
// Easing curve result checker
// Watches the command and result channels, computes the expected curve value
// for every command beat taken, and compares each result beat in order.
// ----------------------------------------------------------------------------
module easing_curve_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_o,
  input  logic [7:0]         command_i,
  input  logic [16:0]        t_in_i,
  input  logic               done_o,
  input  logic signed [17:0] eased_value_o,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE   = 64'sd65536;
  localparam longint HALF  = 64'sd32768;
  localparam int     DEPTH = 256;

  logic signed [17:0] eased_q[$];
  longint             sine_tbl[DEPTH+1];
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = eased_q.size();

  // Round n/d to nearest, ties toward +inf
  function automatic longint div_round(longint n, longint d);
    longint m;
    longint q;
    m = n + d / 2;
    q = m / d;
    if ((m % d) != 0 && m < 0) q--;
    return q;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return div_round(a * b, ONE);
  endfunction

  function automatic longint pow_in(longint u, int p);
    longint r;
    r = u;
    for (int i = 1; i < p; i++) r = qmul(r, u);
    return r;
  endfunction

  // Build the quarter-wave table by the Q.30 Taylor series
  function automatic longint series_sine(int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          s;
    x    = (64'd1686629713 * longint'(k)) / DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2) s -= longint'(term);
      else s += longint'(term);
    end
    if (s < 0) s = 0;
    if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
    return longint'((longint'(s) * ONE + (64'sd1 << 29)) >>> 30);
  endfunction

  function automatic longint sine_at(longint u);
    longint p;
    longint idx;
    longint fr;
    p   = u * DEPTH;
    idx = p >>> 16;
    fr  = p & (ONE - 1);
    if (idx >= DEPTH) return sine_tbl[DEPTH];
    return sine_tbl[idx] + div_round((sine_tbl[idx+1] - sine_tbl[idx]) * fr, ONE);
  endfunction

  // Half curves: 0..2 in p=2..4, 3..5 out p=2..4, 6 sine out, 7 sine in
  function automatic longint half_curve(int id, longint u);
    if (id <= 2) return pow_in(u, id + 2);
    if (id <= 5) return ONE - pow_in(ONE - u, id - 1);
    if (id == 6) return sine_at(u);
    return ONE - sine_at(ONE - u);
  endfunction

  function automatic longint split_blend(longint t, int lo, int hi);
    if (t < HALF) return div_round(half_curve(lo, 2 * t), 2);
    return HALF + div_round(half_curve(hi, 2 * t - ONE), 2);
  endfunction

  function automatic longint overshoot_quad(longint t, int w);
    longint two_a;
    two_a = ece_pkg::OVER_TWO_A[w];
    return div_round(t * (100 * t - two_a * ONE), (100 - two_a) * ONE);
  endfunction

  function automatic logic signed [17:0] predict_eased(logic [7:0] cmd, logic [16:0] t_raw);
    longint t;
    longint v;
    longint t2;
    ece_pkg::curve_e crv;
    t   = (t_raw > ONE) ? ONE : longint'(t_raw);
    crv = (cmd > 8'd31) ? ece_pkg::CRV_LINEAR : ece_pkg::curve_e'(cmd[4:0]);
    case (crv)
      ece_pkg::CRV_IN2, ece_pkg::CRV_IN3, ece_pkg::CRV_IN4:
        v = pow_in(t, int'(crv) + 1);
      ece_pkg::CRV_OUT2, ece_pkg::CRV_OUT3, ece_pkg::CRV_OUT4:
        v = ONE - pow_in(ONE - t, int'(crv) - 2);
      ece_pkg::CRV_SMOOTH: begin
        t2 = qmul(t, t);
        v  = 3 * t2 - 2 * qmul(t2, t);
      end
      ece_pkg::CRV_INOUT2, ece_pkg::CRV_INOUT3, ece_pkg::CRV_INOUT4:
        v = split_blend(t, int'(crv) - 9, int'(crv) - 6);
      ece_pkg::CRV_OUTIN2, ece_pkg::CRV_OUTIN3, ece_pkg::CRV_OUTIN4:
        v = split_blend(t, int'(crv) - 9, int'(crv) - 12);
      ece_pkg::CRV_STEP_END:   v = (t >= ONE) ? ONE : 0;
      ece_pkg::CRV_STEP_START: v = (t > 0) ? ONE : 0;
      ece_pkg::CRV_IN2_ALT:    v = qmul(t, t);
      ece_pkg::CRV_SINE_OUT:   v = half_curve(6, t);
      ece_pkg::CRV_SINE_IN:    v = half_curve(7, t);
      ece_pkg::CRV_SINE_INOUT: v = split_blend(t, 7, 6);
      ece_pkg::CRV_SINE_OUTIN: v = split_blend(t, 6, 7);
      ece_pkg::CRV_OVER0, ece_pkg::CRV_OVER1, ece_pkg::CRV_OVER2,
      ece_pkg::CRV_OVER3, ece_pkg::CRV_OVER4:
        v = overshoot_quad(t, int'(crv) - 22);
      ece_pkg::CRV_OVER_MIR0, ece_pkg::CRV_OVER_MIR1, ece_pkg::CRV_OVER_MIR2,
      ece_pkg::CRV_OVER_MIR3, ece_pkg::CRV_OVER_MIR4:
        v = ONE - overshoot_quad(ONE - t, int'(crv) - 27);
      default: v = t;
    endcase
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[17:0];
  endfunction

  initial begin
    fails = 0;
    for (int k = 0; k <= DEPTH; k++) sine_tbl[k] = series_sine(k);
  end

  // Predict on command beats, compare on result beats
  always @(posedge clk_i) begin
    logic signed [17:0] exp_v;
    if (rst_ni) begin
      if (done_o) begin
        if (eased_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result beat: got %0d", eased_value_o);
        end else begin
          exp_v = eased_q.pop_front();
          if (eased_value_o !== exp_v) begin
            fails++;
            if (fails <= 10) $display("eased_value mismatch: expected %0d got %0d",
                                      exp_v, eased_value_o);
          end
        end
      end
      if (start_i && !busy_o) eased_q.push_back(predict_eased(command_i, t_in_i));
    end
  end
endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// Easing curve evaluator testbench
// Drives directed and random curve commands with random gaps and checks every
// result against an independent fixed-point prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [7:0]         command_i;
  logic [16:0]        t_in_i;
  logic               done_o;
  logic signed [17:0] eased_value_o;
  int                 fail_count;
  int                 pending;
  int                 cycles;

  easing_curve_eval u_top (.*);

  easing_curve_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_o, .command_i, .t_in_i, .done_o, .eased_value_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Bound the run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 200000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Present one beat after an optional gap and hold until taken
  task automatic send_beat(logic [7:0] cmd, logic [16:0] t, int idle_pct);
    while ($urandom_range(99, 0) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    command_i <= cmd;
    t_in_i    <= t;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  function automatic logic [16:0] rand_t();
    case ($urandom_range(9, 0))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'(32'd32768 + $urandom_range(2, 0) - 32'd1);
      3: return 17'($urandom_range(131071, 65537));
      default: return 17'($urandom_range(65536, 0));
    endcase
  endfunction

  initial begin
    int idle_pct;
    rst_ni    = 1'b0;
    start_i   = 1'b0;
    command_i = '0;
    t_in_i    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every curve at a few points, fallback code, saturated t
    for (int c = 0; c < 32; c++) begin
      send_beat(c[7:0], 17'd0, 0);
      send_beat(c[7:0], 17'd65536, 0);
      send_beat(c[7:0], 17'd32768, 0);
      send_beat(c[7:0], 17'd32767, 0);
      send_beat(c[7:0], 17'h1FFFF, 0);
    end
    send_beat(8'd32, 17'd12345, 0);
    send_beat(8'd255, 17'd65535, 0);
    send_beat(8'hAA, 17'h15555, 0);

    // Random: sender busy, then quiet, then back to back
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 38 : (ph == 1) ? 59 : 0;
      for (int i = 0; i < 280; i++) begin
        if ($urandom_range(9, 0) == 0) begin
          send_beat(8'($urandom_range(255, 0)), rand_t(), idle_pct);
        end else begin
          send_beat(8'($urandom_range(31, 0)), rand_t(), idle_pct);
        end
      end
    end
    start_i <= 1'b0;

    // Drain and let the pipeline settle
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
